### rtl/core/imsm_pkg.sv
// ----------------------------------------------------------------------------
// imsm_pkg
// Shared types, constants and codes of the input mapping stack machine.
// ----------------------------------------------------------------------------
package imsm_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int AXIS_COUNT_DEF  = 32;
  localparam int KEY_COUNT_DEF   = 256;

  // command codes
  localparam logic [2:0] CMD_PRESS   = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_PUSH    = 3'd2;
  localparam logic [2:0] CMD_EXEC    = 3'd3;
  localparam logic [2:0] CMD_START   = 3'd4;

  // word codes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_AXIS = 4'd1;
  localparam logic [3:0] OP_CLR  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_KEY  = 4'd4;
  localparam logic [3:0] OP_MUL  = 4'd5;
  localparam logic [3:0] OP_NEG  = 4'd6;
  localparam logic [3:0] OP_SUB  = 4'd7;
  localparam logic [3:0] OP_TRIG = 4'd8;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OVER   = 3'd1;
  localparam logic [2:0] ST_UNDER  = 3'd2;
  localparam logic [2:0] ST_BADKEY = 3'd3;
  localparam logic [2:0] ST_SKIP   = 3'd4;
  localparam logic [2:0] ST_BADIDX = 3'd5;
  localparam logic [2:0] ST_KEYIGN = 3'd6;

  // event kinds
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_AXIS = 2'd1;
  localparam logic [1:0] EV_TRIG = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_AXRD,
    S_AXCMP,
    S_WB,
    S_OUT
  } state_t;

  // divider request and reply
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] q;
  } div_rsp_t;

endpackage

### rtl/core/imsm_ram.sv
// ----------------------------------------------------------------------------
// imsm_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module imsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read registered; a read during a write returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/imsm_div.sv
// ----------------------------------------------------------------------------
// imsm_div
// Iterative Q16.16 divider: (a * 2^16) / b, truncated toward zero, saturated.
// One quotient bit per cycle over a 48-bit dividend.
// ----------------------------------------------------------------------------
module imsm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  imsm_pkg::div_req_t  req,
  output imsm_pkg::div_rsp_t  rsp
);

  logic [47:0] num_r, num_nxt;
  logic [31:0] den_r;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        neg_r;
  logic        zero_r;
  logic        done_r;
  logic [31:0] q_r;
  logic [33:0] trial;
  logic [48:0] qs;
  logic [31:0] ua;
  logic [31:0] ub;

  assign ua = req.a[31] ? (~req.a + 32'd1) : req.a;
  assign ub = req.b[31] ? (~req.b + 32'd1) : req.b;

  // restoring step
  always_comb begin
    trial   = {rem_r, num_r[47]} - {2'b00, den_r};
    num_nxt = {num_r[46:0], ~trial[33]};
    rem_nxt = trial[33] ? {rem_r[31:0], num_r[47]} : trial[32:0];
  end

  // signed quotient, saturated when loaded into q_r
  assign qs = neg_r ? (~{1'b0, num_nxt} + 49'd1) : {1'b0, num_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd47;
        num_r  <= {ua, 16'd0};
        den_r  <= ub;
        rem_r  <= '0;
        neg_r  <= req.a[31] ^ req.b[31];
        zero_r <= (req.a == 32'd0);
      end else if (busy_r) begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          // zero dividend gives zero, also over a zero divisor
          if (zero_r) begin
            q_r <= '0;
          end else if (!neg_r && num_nxt > 48'h0000_7FFF_FFFF) begin
            q_r <= 32'h7FFF_FFFF;
          end else if (neg_r && num_nxt > 48'h0000_8000_0000) begin
            q_r <= 32'h8000_0000;
          end else begin
            q_r <= qs[31:0];
          end
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

### rtl/core/input_mapping_stack_machine_top.sv
// ----------------------------------------------------------------------------
// input_mapping_stack_machine_top
// Key map and Q16.16 stack machine running an input script.
// ----------------------------------------------------------------------------
// One item is handled at a time and gives exactly one result transfer. After
// reset the axis store (AXIS_COUNT rounded up to a power of two) is swept to
// zero and no item is taken meanwhile. Key commands, start run, a push,
// clearstack and any skipped or underflowing word go from S_IDLE to S_OUT; a
// one-operand word passes S_EXEC and S_WB, add and subtract S_RD1, S_RD2, S_EXEC
// and S_WB, multiply adds S_MUL, axis and trigger S_AXRD and S_AXCMP, and
// divide S_DIV, set by the bit-serial divider (48 quotient bits, one per cycle).
// The output register must be free or draining before it is loaded, so a
// stalled result adds its wait to the next item.
// The operand stack and the axis values live in single-port RAMs; the key map
// is a flip-flop vector.
module input_mapping_stack_machine_top #(
  parameter int STACK_DEPTH = imsm_pkg::STACK_DEPTH_DEF,
  parameter int AXIS_COUNT  = imsm_pkg::AXIS_COUNT_DEF,
  parameter int KEY_COUNT   = imsm_pkg::KEY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[2:0], key_id[12:3], word_op[16:13], number_value[48:17], zero fill
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], event_kind[4:3], event_index[9:5], event_value[41:10],
  // stack_depth[51:42], zero fill
  output logic [55:0] out_tdata
);

  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int AXW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int KW  = $clog2(KEY_COUNT);
  localparam logic [31:0] KEY_MAX = 32'(KEY_COUNT - 1) << 16;

  imsm_pkg::state_t state_r, state_nxt;

  // item fields
  logic [2:0]  cmd;
  logic [9:0]  key_id;
  logic [3:0]  word_op;
  logic [31:0] number_value;
  assign cmd          = in_tdata[2:0];
  assign key_id       = in_tdata[12:3];
  assign word_op      = in_tdata[16:13];
  assign number_value = in_tdata[48:17];

  logic [3:0]     op_r;
  logic [SPW:0]   sp_r;
  logic           abort_r;
  logic [KEY_COUNT-1:0] keys_r;
  logic [31:0]    a_r, b_r, res_r;
  logic [2:0]     st_r;
  logic [1:0]     kind_r;
  logic [4:0]     idx_r;
  logic [31:0]    val_r;
  logic [AXW:0]   clr_r;
  logic [AXW-1:0] axi_r;
  logic [63:0]    prod_r;
  logic           out_v_r;
  logic [51:0]    out_d_r;

  // memories
  logic            s_we, x_we;
  logic [SPW-1:0]  s_addr;
  logic [AXW-1:0]  x_addr;
  logic [31:0]     s_wd, s_rd, x_wd, x_rd;

  imsm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd)
  );
  imsm_ram #(.WIDTH(32), .DEPTH(1 << AXW)) u_axis (
    .clk(clk), .we(x_we), .addr(x_addr), .wdata(x_wd), .rdata(x_rd)
  );

  imsm_pkg::div_req_t dreq;
  imsm_pkg::div_rsp_t drsp;
  imsm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // arithmetic helpers
  logic [32:0] sum33, dif33, neg33;
  logic [31:0] sum_s, dif_s, neg_s;
  logic [31:0] ip_b, ip_a;
  logic [47:0] pq;
  logic [31:0] mul_s;
  always_comb begin
    sum33 = {a_r[31], a_r} + {b_r[31], b_r};
    dif33 = {a_r[31], a_r} - {b_r[31], b_r};
    neg33 = 33'd0 - {b_r[31], b_r};
    sum_s = (sum33[32] != sum33[31]) ? (sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                     : sum33[31:0];
    dif_s = (dif33[32] != dif33[31]) ? (dif33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                     : dif33[31:0];
    neg_s = (neg33[32] != neg33[31]) ? 32'h7FFF_FFFF : neg33[31:0];
    // truncation toward zero of the integer part
    ip_b  = b_r[31] ? (32'd0 - ((32'd0 - b_r) >> 16)) : (b_r >> 16);
    ip_a  = a_r[31] ? (32'd0 - ((32'd0 - a_r) >> 16)) : (a_r >> 16);
    // floor shift of the product, then saturate
    pq    = prod_r[63:16];
    if ($signed(pq) > $signed(48'h0000_7FFF_FFFF)) mul_s = 32'h7FFF_FFFF;
    else if ($signed(pq) < $signed(48'hFFFF_8000_0000)) mul_s = 32'h8000_0000;
    else mul_s = pq[31:0];
  end

  logic idx_ok;
  assign idx_ok = !ip_b[31] && (ip_b < 32'(AXIS_COUNT));

  // state register and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imsm_pkg::S_CLEAR;
      sp_r    <= '0;
      abort_r <= 1'b0;
      keys_r  <= '0;
      clr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result register loads when free or draining, else clears on transfer
      if (state_r == imsm_pkg::S_OUT && (!out_v_r || out_tready)) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        imsm_pkg::S_CLEAR: clr_r <= clr_r + 1'b1;
        imsm_pkg::S_IDLE: begin
          if (in_tvalid) begin
            op_r   <= word_op;
            st_r   <= imsm_pkg::ST_OK;
            kind_r <= imsm_pkg::EV_NONE;
            idx_r  <= '0;
            val_r  <= '0;
            case (cmd)
              imsm_pkg::CMD_PRESS, imsm_pkg::CMD_RELEASE: begin
                if ({1'b0, key_id} >= 11'(KEY_COUNT)) st_r <= imsm_pkg::ST_KEYIGN;
                else keys_r[key_id[KW-1:0]] <= (cmd == imsm_pkg::CMD_PRESS);
              end
              imsm_pkg::CMD_START: begin
                sp_r    <= '0;
                abort_r <= 1'b0;
              end
              imsm_pkg::CMD_PUSH, imsm_pkg::CMD_EXEC: begin
                if (abort_r) st_r <= imsm_pkg::ST_SKIP;
                else if (cmd == imsm_pkg::CMD_PUSH) begin
                  if (sp_r >= (SPW+1)'(STACK_DEPTH - 1)) begin
                    st_r    <= imsm_pkg::ST_OVER;
                    abort_r <= 1'b1;
                  end else sp_r <= sp_r + 1'b1;
                end else if (word_op == imsm_pkg::OP_CLR || word_op > imsm_pkg::OP_TRIG) begin
                  sp_r <= '0;
                end else if (((word_op == imsm_pkg::OP_KEY || word_op == imsm_pkg::OP_NEG)
                              && sp_r == '0) || sp_r < (SPW+1)'(2)) begin
                  if (!((word_op == imsm_pkg::OP_KEY || word_op == imsm_pkg::OP_NEG)
                        && sp_r != '0)) begin
                    st_r    <= imsm_pkg::ST_UNDER;
                    abort_r <= 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        imsm_pkg::S_RD1: b_r <= s_rd;
        imsm_pkg::S_RD2: ;
        imsm_pkg::S_EXEC: begin
          if (op_r == imsm_pkg::OP_KEY || op_r == imsm_pkg::OP_NEG) begin
            b_r <= s_rd;
          end else begin
            a_r <= s_rd;
          end
        end
        imsm_pkg::S_MUL: prod_r <= 64'($signed(a_r) * $signed(b_r));
        imsm_pkg::S_DIV: if (drsp.done) res_r <= drsp.q;
        imsm_pkg::S_AXRD: axi_r <= ip_b[AXW-1:0];
        imsm_pkg::S_AXCMP: begin
          // events only for an axis or trigger number in range
          if (idx_ok) begin
            if (op_r == imsm_pkg::OP_AXIS) begin
              if (x_rd != a_r) begin
                kind_r <= imsm_pkg::EV_AXIS;
                idx_r  <= 5'(axi_r);
                val_r  <= a_r;
              end
            end else if (ip_a != 32'd0) begin
              kind_r <= imsm_pkg::EV_TRIG;
              idx_r  <= 5'(axi_r);
            end
          end
        end
        imsm_pkg::S_WB: begin
          case (op_r)
            imsm_pkg::OP_NEG, imsm_pkg::OP_KEY: ;
            imsm_pkg::OP_AXIS, imsm_pkg::OP_TRIG: begin
              sp_r <= sp_r - (SPW+1)'(2);
              if (!idx_ok) st_r <= imsm_pkg::ST_BADIDX;
            end
            default: sp_r <= sp_r - 1'b1;
          endcase
          if (op_r == imsm_pkg::OP_KEY &&
              (b_r[31] || b_r > KEY_MAX)) begin
            st_r    <= imsm_pkg::ST_BADKEY;
            abort_r <= 1'b1;
          end
        end
        imsm_pkg::S_OUT: begin
          if (!out_v_r || out_tready) begin
            out_d_r <= {10'(sp_r), val_r, idx_r, kind_r, st_r};
          end
        end
        default: ;
      endcase
    end
  end

  // next state, memory ports
  logic needs_rd;
  always_comb begin
    state_nxt = state_r;
    s_we   = 1'b0;
    s_addr = sp_r[SPW-1:0] - 1'b1;
    s_wd   = number_value;
    x_we   = 1'b0;
    x_addr = clr_r[AXW-1:0];
    x_wd   = '0;
    dreq   = '0;
    needs_rd = 1'b0;
    unique case (state_r)
      imsm_pkg::S_CLEAR: begin
        x_we = 1'b1;
        if (clr_r == (AXW+1)'((1 << AXW) - 1)) state_nxt = imsm_pkg::S_IDLE;
      end
      imsm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = imsm_pkg::S_OUT;
          if (cmd == imsm_pkg::CMD_PUSH && !abort_r &&
              sp_r < (SPW+1)'(STACK_DEPTH - 1)) begin
            s_we   = 1'b1;
            s_addr = sp_r[SPW-1:0];
          end
          if (cmd == imsm_pkg::CMD_EXEC && !abort_r &&
              word_op != imsm_pkg::OP_CLR && word_op <= imsm_pkg::OP_TRIG) begin
            if (word_op == imsm_pkg::OP_KEY || word_op == imsm_pkg::OP_NEG)
              needs_rd = (sp_r != '0);
            else
              needs_rd = (sp_r >= (SPW+1)'(2));
          end
          if (needs_rd) begin
            // top first
            s_addr    = sp_r[SPW-1:0] - 1'b1;
            state_nxt = (word_op == imsm_pkg::OP_KEY || word_op == imsm_pkg::OP_NEG)
                        ? imsm_pkg::S_EXEC : imsm_pkg::S_RD1;
          end
        end
      end
      imsm_pkg::S_RD1: begin
        s_addr    = sp_r[SPW-1:0] - SPW'(2);
        state_nxt = imsm_pkg::S_RD2;
      end
      imsm_pkg::S_RD2: begin
        s_addr    = sp_r[SPW-1:0] - SPW'(2);
        state_nxt = imsm_pkg::S_EXEC;
      end
      imsm_pkg::S_EXEC: begin
        case (op_r)
          imsm_pkg::OP_MUL: state_nxt = imsm_pkg::S_MUL;
          imsm_pkg::OP_DIV: state_nxt = imsm_pkg::S_DIV;
          imsm_pkg::OP_AXIS, imsm_pkg::OP_TRIG: state_nxt = imsm_pkg::S_AXRD;
          imsm_pkg::OP_KEY, imsm_pkg::OP_NEG: state_nxt = imsm_pkg::S_WB;
          default: state_nxt = imsm_pkg::S_WB;
        endcase
        if (op_r == imsm_pkg::OP_DIV) begin
          dreq.start = 1'b1;
          dreq.a     = s_rd;
          dreq.b     = b_r;
        end
      end
      imsm_pkg::S_MUL: state_nxt = imsm_pkg::S_WB;
      imsm_pkg::S_DIV: if (drsp.done) state_nxt = imsm_pkg::S_WB;
      imsm_pkg::S_AXRD: begin
        x_addr    = ip_b[AXW-1:0];
        state_nxt = imsm_pkg::S_AXCMP;
      end
      imsm_pkg::S_AXCMP: begin
        x_addr    = axi_r;
        state_nxt = imsm_pkg::S_WB;
        if (op_r == imsm_pkg::OP_AXIS && idx_ok && x_rd != a_r) begin
          x_we = 1'b1;
          x_wd = a_r;
        end
      end
      imsm_pkg::S_WB: begin
        state_nxt = imsm_pkg::S_OUT;
        case (op_r)
          imsm_pkg::OP_NEG: begin
            s_we = 1'b1;
            s_wd = neg_s;
          end
          imsm_pkg::OP_KEY: begin
            s_we = !(b_r[31] || b_r > KEY_MAX);
            s_wd = keys_r[ip_b[KW-1:0]] ? 32'h0001_0000 : 32'd0;
          end
          imsm_pkg::OP_ADD, imsm_pkg::OP_SUB, imsm_pkg::OP_MUL, imsm_pkg::OP_DIV: begin
            s_we   = 1'b1;
            s_addr = sp_r[SPW-1:0] - SPW'(2);
            case (op_r)
              imsm_pkg::OP_ADD: s_wd = sum_s;
              imsm_pkg::OP_SUB: s_wd = dif_s;
              imsm_pkg::OP_MUL: s_wd = mul_s;
              default:          s_wd = res_r;
            endcase
          end
          default: ;
        endcase
      end
      imsm_pkg::S_OUT: begin
        if (!out_v_r || out_tready) state_nxt = imsm_pkg::S_IDLE;
      end
      default: state_nxt = imsm_pkg::S_IDLE;
    endcase
  end

  // S_OUT loads the output register only when it may; hold otherwise
  assign in_tready  = (state_r == imsm_pkg::S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_d_r};

  // index register only meaningful when in range; keep its use masked above

  // a result is never overwritten while waiting
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  // no item is taken while a result is being built
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken mid-work");
  // stack pointer never exceeds the memory
  a_sp: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= (SPW+1)'(STACK_DEPTH - 1))
    else $error("stack pointer out of range");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the input mapping stack machine: a table of
// directed script symbols, a fill to overflow, then random runs, all checked
// against a behavioural predictor of the key map, operand stack and axes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SDEPTH   = 1024;
  localparam int NAXIS    = 32;
  localparam int NKEY     = 256;
  localparam int N_RANDOM = 200;
  localparam int WD_LIMIT = 20000;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  // packed lowest field last, matching out_tdata
  typedef struct packed {
    logic [9:0]  depth;
    logic [31:0] val;
    logic [4:0]  idx;
    logic [1:0]  kind;
    logic [2:0]  st;
  } result_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [9:0]  key;
    logic [3:0]  op;
    logic [31:0] num;
    logic        has_exp;
    result_t     exp_res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  // predictor state
  logic [NKEY-1:0]          p_keys;
  logic signed [31:0]       p_stack [SDEPTH];
  int                       p_sp;
  logic signed [31:0]       p_axes [NAXIS];
  logic                     p_aborted;

  result_t expected_results [$];
  int      errors;
  int      idle_cycles;
  bit      stim_done;
  bit      hold_off;

  input_mapping_stack_machine_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] clip(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return SMAX;
    if (v < -64'sd2147483648) return SMIN;
    return v[31:0];
  endfunction

  // integer part, truncated toward zero
  function automatic longint whole(input logic signed [31:0] v);
    longint w;
    w = v;
    if (w >= 0) return w >>> 16;
    return -((-w) >>> 16);
  endfunction

  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    if (p >= 0) return clip(p >>> 16);
    return clip(-(((-p) + 64'sd65535) >>> 16));
  endfunction

  function automatic logic signed [31:0] q_div(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] n;
    if (b == 0) begin
      if (a > 0) return SMAX;
      if (a < 0) return SMIN;
      return 32'sd0;
    end
    n = 64'(a) * 64'sd65536;
    return clip(n / 64'(b));
  endfunction

  // run one script word on the predicted stack
  function automatic logic [2:0] run_word(input logic [3:0] op, inout result_t r);
    logic signed [31:0] a, b;
    longint n;
    if (op == imsm_pkg::OP_CLR || op > imsm_pkg::OP_TRIG) begin
      p_sp = 0;
      return imsm_pkg::ST_OK;
    end
    if (op == imsm_pkg::OP_KEY || op == imsm_pkg::OP_NEG) begin
      if (p_sp < 1) return imsm_pkg::ST_UNDER;
      a = p_stack[p_sp-1];
      if (op == imsm_pkg::OP_NEG) begin
        p_stack[p_sp-1] = clip(-64'(a));
        return imsm_pkg::ST_OK;
      end
      if (a < 0 || longint'(a) > longint'(NKEY-1) * 65536) return imsm_pkg::ST_BADKEY;
      p_stack[p_sp-1] = p_keys[whole(a)] ? 32'sd65536 : 32'sd0;
      return imsm_pkg::ST_OK;
    end
    if (p_sp < 2) return imsm_pkg::ST_UNDER;
    a = p_stack[p_sp-2];
    b = p_stack[p_sp-1];
    case (op)
      imsm_pkg::OP_ADD: p_stack[p_sp-2] = clip(64'(a) + 64'(b));
      imsm_pkg::OP_SUB: p_stack[p_sp-2] = clip(64'(a) - 64'(b));
      imsm_pkg::OP_MUL: p_stack[p_sp-2] = q_mul(a, b);
      imsm_pkg::OP_DIV: p_stack[p_sp-2] = q_div(a, b);
      default: begin
        p_sp = p_sp - 2;
        n = whole(b);
        if (n < 0 || n >= NAXIS) return imsm_pkg::ST_BADIDX;
        if (op == imsm_pkg::OP_AXIS) begin
          if (p_axes[n] != a) begin
            p_axes[n] = a;
            r.kind = imsm_pkg::EV_AXIS;
            r.idx = n[4:0];
            r.val = a;
          end
        end else if (whole(a) != 0) begin
          r.kind = imsm_pkg::EV_TRIG;
          r.idx = n[4:0];
        end
        return imsm_pkg::ST_OK;
      end
    endcase
    p_sp = p_sp - 1;
    return imsm_pkg::ST_OK;
  endfunction

  // expected result of one script symbol, advancing the predicted state
  function automatic result_t predict_symbol(input logic [2:0] cmd, input logic [9:0] key,
                                             input logic [3:0] op, input logic [31:0] num);
    result_t r;
    r = '0;
    if (cmd == imsm_pkg::CMD_PRESS || cmd == imsm_pkg::CMD_RELEASE) begin
      if (key >= NKEY) r.st = imsm_pkg::ST_KEYIGN;
      else p_keys[key] = (cmd == imsm_pkg::CMD_PRESS);
    end else if (cmd == imsm_pkg::CMD_START) begin
      p_sp = 0;
      p_aborted = 1'b0;
    end else if (cmd == imsm_pkg::CMD_PUSH || cmd == imsm_pkg::CMD_EXEC) begin
      if (p_aborted) r.st = imsm_pkg::ST_SKIP;
      else if (cmd == imsm_pkg::CMD_PUSH) begin
        if (p_sp >= SDEPTH-1) r.st = imsm_pkg::ST_OVER;
        else begin
          p_stack[p_sp] = num;
          p_sp++;
        end
      end else r.st = run_word(op, r);
      if (r.st == imsm_pkg::ST_OVER || r.st == imsm_pkg::ST_UNDER ||
          r.st == imsm_pkg::ST_BADKEY) p_aborted = 1'b1;
    end
    r.depth = p_sp[9:0];
    return r;
  endfunction

  // send one symbol after a random gap and queue its expected result
  task automatic send_symbol(input logic [2:0] cmd, input logic [9:0] key,
                             input logic [3:0] op, input logic [31:0] num,
                             input bit has_exp, input result_t exp_res);
    int gap;
    result_t r;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r = predict_symbol(cmd, key, op, num);
    if (has_exp && r != exp_res) begin
      $display("%0t predictor disagrees with table: exp %h got %h", $time, exp_res, r);
      errors++;
    end
    expected_results.push_back(has_exp ? exp_res : r);
    in_tdata  <= {7'd0, num, op, key, cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic result_t res(input logic [2:0] st, input logic [9:0] depth);
    result_t r;
    r = '0;
    r.st = st;
    r.depth = depth;
    return r;
  endfunction

  // stimulus
  initial begin
    row_t    dir [25];
    row_t    t;
    int      kind;
    int      run_len;
    logic [31:0] v;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    stim_done = 1'b0;
    p_keys = '0;
    p_sp = 0;
    p_aborted = 1'b0;
    foreach (p_stack[i]) p_stack[i] = '0;
    foreach (p_axes[i]) p_axes[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: extremes, every word but clearstack, special cases
    dir = '{
      '{imsm_pkg::CMD_EXEC,  10'd0,   imsm_pkg::OP_ADD,  32'd0, 1'b1,
        res(imsm_pkg::ST_UNDER, 10'd0)},
      '{imsm_pkg::CMD_PUSH,  10'd0,   imsm_pkg::OP_ADD,  32'd5, 1'b1,
        res(imsm_pkg::ST_SKIP, 10'd0)},
      '{imsm_pkg::CMD_START, 10'd0,   imsm_pkg::OP_ADD,  32'd0, 1'b1,
        res(imsm_pkg::ST_OK, 10'd0)},
      '{imsm_pkg::CMD_PRESS, 10'd255, imsm_pkg::OP_ADD,  32'd0, 1'b1,
        res(imsm_pkg::ST_OK, 10'd0)},
      '{imsm_pkg::CMD_PRESS, 10'd1023, imsm_pkg::OP_ADD, 32'd0, 1'b1,
        res(imsm_pkg::ST_KEYIGN, 10'd0)},
      '{imsm_pkg::CMD_PUSH,  10'd0,   imsm_pkg::OP_ADD,  32'h7fffffff, 1'b1,
        res(imsm_pkg::ST_OK, 10'd1)},
      '{imsm_pkg::CMD_PUSH,  10'd0,   imsm_pkg::OP_ADD,  32'h7fffffff, 1'b1,
        res(imsm_pkg::ST_OK, 10'd2)},
      '{imsm_pkg::CMD_EXEC,  10'd0,   imsm_pkg::OP_ADD,  32'd0, 1'b0, '0},
      '{imsm_pkg::CMD_PUSH,  10'd0,   imsm_pkg::OP_ADD,  32'h80000000, 1'b0, '0},
      '{imsm_pkg::CMD_EXEC,  10'd0,   imsm_pkg::OP_MUL,  32'd0, 1'b0, '0},
      '{imsm_pkg::CMD_PUSH,  10'd0,   imsm_pkg::OP_ADD,  32'd0, 1'b0, '0},
      '{imsm_pkg::CMD_EXEC,  10'd0,   imsm_pkg::OP_DIV,  32'd0, 1'b0, '0},
      '{imsm_pkg::CMD_EXEC,  10'd0,   imsm_pkg::OP_NEG,  32'd0, 1'b0, '0},
      '{imsm_pkg::CMD_PUSH,  10'd0,   imsm_pkg::OP_ADD,  32'h00030000, 1'b0, '0},
      '{imsm_pkg::CMD_EXEC,  10'd0,   imsm_pkg::OP_SUB,  32'd0, 1'b0, '0},
      '{imsm_pkg::CMD_PUSH,  10'd0,   imsm_pkg::OP_ADD,  32'h00050000, 1'b0, '0},
      '{imsm_pkg::CMD_EXEC,  10'd0,   imsm_pkg::OP_AXIS, 32'd0, 1'b0, '0},
      '{imsm_pkg::CMD_PUSH,  10'd0,   imsm_pkg::OP_ADD,  32'h00ff0000, 1'b0, '0},
      '{imsm_pkg::CMD_EXEC,  10'd0,   imsm_pkg::OP_KEY,  32'd0, 1'b1,
        res(imsm_pkg::ST_OK, 10'd1)},
      '{imsm_pkg::CMD_PUSH,  10'd0,   imsm_pkg::OP_ADD,  32'h00200000, 1'b0, '0},
      '{imsm_pkg::CMD_EXEC,  10'd0,   imsm_pkg::OP_TRIG, 32'd0, 1'b1,
        res(imsm_pkg::ST_BADIDX, 10'd0)},
      '{imsm_pkg::CMD_PUSH,  10'd0,   imsm_pkg::OP_ADD,  32'hffffffff, 1'b0, '0},
      '{imsm_pkg::CMD_EXEC,  10'd0,   imsm_pkg::OP_KEY,  32'd0, 1'b1,
        res(imsm_pkg::ST_BADKEY, 10'd1)},
      '{imsm_pkg::CMD_START, 10'd0,   4'd15,   32'd0, 1'b0, '0},
      '{3'd7,                10'd0,   4'd15,   32'd0, 1'b1,
        res(imsm_pkg::ST_OK, 10'd0)}
    };
    foreach (dir[i]) begin
      t = dir[i];
      send_symbol(t.cmd, t.key, t.op, t.num, t.has_exp, t.exp_res);
    end

    // fill to overflow once
    for (int i = 0; i < SDEPTH; i++)
      send_symbol(imsm_pkg::CMD_PUSH, 10'd0, imsm_pkg::OP_ADD, $urandom, 1'b0, '0);
    send_symbol(imsm_pkg::CMD_START, 10'd0, imsm_pkg::OP_ADD, 32'd0, 1'b0, '0);

    // random runs: mostly well-formed scripts, some noise
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = {$urandom_range(0, 40) > 33 ? 16'hffff : 16'($urandom_range(0, 40)),
                16'($urandom)};
        2: v = {16'($urandom_range(0, 31)), 16'd0};
        default: v = {16'($urandom_range(0, 255)), ($urandom_range(0, 1) ? 16'($urandom) : 16'd0)};
      endcase
      if (kind < 40)
        send_symbol(imsm_pkg::CMD_PUSH, 10'($urandom), 4'($urandom), v, 1'b0, '0);
      else if (kind < 78)
        send_symbol(imsm_pkg::CMD_EXEC, 10'($urandom), 4'($urandom_range(0, 8)), v, 1'b0, '0);
      else if (kind < 80)
        send_symbol(imsm_pkg::CMD_EXEC, 10'($urandom), 4'($urandom_range(9, 15)), v, 1'b0, '0);
      else if (kind < 92)
        send_symbol(3'($urandom_range(0, 1)), 10'($urandom_range(0, 300)), 4'($urandom),
                    v, 1'b0, '0);
      else if (kind < 98)
        send_symbol(imsm_pkg::CMD_START, 10'($urandom), 4'($urandom), v, 1'b0, '0);
      else
        send_symbol(3'($urandom_range(5, 7)), 10'($urandom), 4'($urandom), v, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off early on
  initial begin
    int gap;
    out_tready = 1'b0;
    hold_off = 1'b1;
    @(posedge rst_n);
    repeat (40) @(posedge clk);
    for (int i = 0; i < 600; i++) @(posedge clk);
    hold_off = 1'b0;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // result checking
  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[51:0];
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.st != exp_r.st || got.kind != exp_r.kind || got.idx != exp_r.idx ||
            got.val != exp_r.val || got.depth != exp_r.depth) begin
          $display("%0t mismatch: exp st=%0d kind=%0d idx=%0d val=%h depth=%0d", $time,
                   exp_r.st, exp_r.kind, exp_r.idx, exp_r.val, exp_r.depth);
          $display("%0t          got st=%0d kind=%0d idx=%0d val=%h depth=%0d", $time,
                   got.st, got.kind, got.idx, got.val, got.depth);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // end of run
  initial begin
    errors = 0;
    idle_cycles = 0;
    while (!(stim_done && expected_results.size() == 0) && idle_cycles < WD_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WD_LIMIT) begin
      $display("== FAIL ==");
    end else begin
      repeat (100) @(posedge clk);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
    end
    $finish;
  end

endmodule
